// File: src/wrtl_pkg.sv
// Shared types and constants for the wildcard rule table lookup.
// Used by wrtl_mem, wrtl_draw and wildcard_rule_table_lookup; no dependencies.
package wrtl_pkg;

  localparam int TABLE_DEPTH    = 256;
  localparam int MAX_ALTERNATES = 5;
  localparam int ACTION_CHARS   = 4;
  // The action field holds four characters; the compare covers at most four.
  localparam int ACT_CMP        = (ACTION_CHARS < 4) ? ACTION_CHARS : 4;

  localparam int IDX_W   = 8;
  localparam int PADDR_W = 3;

  localparam logic [31:0] LCG_MUL = 32'h015a_4e35;
  localparam logic [31:0] LCG_INC = 32'h0000_0001;

  localparam logic [7:0]  ANY_TYPE = 8'hFF;
  localparam logic [15:0] ANY_ID   = 16'hFFFF;

  localparam logic [0:0] REG_SEED = 1'b0;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [6:0]  subj_type;
    logic [15:0] subj_id;
    logic [31:0] action;
    logic [7:0]  obj_type;
    logic [15:0] obj_id;
    logic [15:0] effect;
  } rule_t;

  typedef struct packed {
    logic done;
    logic is_zero;
  } draw_rsp_t;

endpackage

// File: src/wrtl_mem.sv
// Rule storage: one synchronous memory, one write port and one read port
// with registered read data. Depends on wrtl_pkg for the entry type.
module wrtl_mem #(
  parameter int DEPTH = wrtl_pkg::TABLE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  wrtl_pkg::rule_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output wrtl_pkg::rule_t rdata_o
);

  wrtl_pkg::rule_t mem_q [DEPTH];
  wrtl_pkg::rule_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/wrtl_draw.sv
// Random draw unit: 32-bit LCG step, then the remainder by a small bound,
// four quotient bits per cycle. Depends on wrtl_pkg.
module wrtl_draw #(
  parameter int MAX_ALT = wrtl_pkg::MAX_ALTERNATES,
  parameter int BW      = $clog2(MAX_ALT + 2)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                seed_we_i,
  input  logic [31:0]         seed_i,
  input  logic                req_valid_i,
  input  logic [BW-1:0]       bound_i,
  output wrtl_pkg::draw_rsp_t rsp_o
);

  localparam int DIGIT = 4;
  localparam int STEPS = 32 / DIGIT;
  localparam int SW    = $clog2(STEPS);

  typedef enum logic {
    D_IDLE,
    D_DIV
  } dstate_e;

  dstate_e             state_q, state_d;
  logic [31:0]         rng_q, rng_d;
  logic [31:0]         div_q, div_d;
  logic [BW-1:0]       rem_q, rem_d;
  logic [BW-1:0]       bound_q, bound_d;
  logic [SW-1:0]       step_q, step_d;
  wrtl_pkg::draw_rsp_t rsp_q, rsp_d;

  logic [31:0]   rng_next;
  logic [BW:0]   part;
  logic [BW-1:0] rem_next;

  assign rng_next = rng_q * wrtl_pkg::LCG_MUL + wrtl_pkg::LCG_INC;

  // Restoring remainder over one digit of the dividend.
  always_comb begin
    part = {1'b0, rem_q};
    for (int b = 0; b < DIGIT; b++) begin
      part = {part[BW-1:0], div_q[31-b]};
      if (part >= {1'b0, bound_q}) begin
        part = part - {1'b0, bound_q};
      end
    end
    rem_next = part[BW-1:0];
  end

  always_comb begin
    state_d = state_q;
    rng_d   = rng_q;
    div_d   = div_q;
    rem_d   = rem_q;
    bound_d = bound_q;
    step_d  = step_q;
    rsp_d   = '0;
    case (state_q)
      D_IDLE: begin
        if (seed_we_i) begin
          rng_d = seed_i;
        end else if (req_valid_i) begin
          rng_d   = rng_next;
          div_d   = rng_next;
          rem_d   = '0;
          bound_d = bound_i;
          step_d  = '0;
          state_d = D_DIV;
        end
      end
      D_DIV: begin
        rem_d  = rem_next;
        div_d  = div_q << DIGIT;
        step_d = step_q + SW'(1);
        if (step_q == SW'(STEPS - 1)) begin
          rsp_d.done    = 1'b1;
          rsp_d.is_zero = (rem_next == '0);
          state_d       = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      rng_q   <= '0;
      step_q  <= '0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      rng_q   <= rng_d;
      step_q  <= step_d;
      rsp_q   <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q   <= div_d;
    rem_q   <= rem_d;
    bound_q <= bound_d;
  end

  assign rsp_o = rsp_q;

endmodule

// File: src/wildcard_rule_table_lookup.sv
// Top level of the wildcard rule table lookup: command sequencer, APB seed
// register. Depends on wrtl_pkg, wrtl_mem and wrtl_draw.
//
// Clear, append and unknown commands finish in S_IDLE; the result strobes on
// done_o in the next cycle and a new request may start then. A query scans
// the table from entry 0 through the single memory read port, one entry per
// cycle, up to the first match. Each further alternate that matches (at most
// MAX_ALTERNATES - 1) adds a read, a compare that also steps the LCG, the
// draw unit's remainder and its registered response. busy stays high until
// the result strobe; the result is shown for exactly one cycle and must be
// taken then.
module wildcard_rule_table_lookup #(
  parameter int TABLE_DEPTH    = wrtl_pkg::TABLE_DEPTH,
  parameter int MAX_ALTERNATES = wrtl_pkg::MAX_ALTERNATES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command_i,
  input  logic [6:0]                   subject_type_i,
  input  logic signed [15:0]           subject_id_i,
  input  logic [31:0]                  action_code_i,
  input  logic signed [7:0]            object_type_i,
  input  logic signed [15:0]           object_id_i,
  input  logic [15:0]                  effect_code_i,
  input  logic                         first_only_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [15:0]                  effect_out_o,
  output logic [wrtl_pkg::IDX_W-1:0]   entry_index_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wrtl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int FW    = $clog2(MAX_ALTERNATES + 1);
  localparam int BW    = $clog2(MAX_ALTERNATES + 2);
  localparam int IDX_W = wrtl_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ALT_READ,
    S_ALT_WAIT,
    S_ALT_DRAW
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     issue_q, issue_d;
  logic              chk_valid_q, chk_valid_d;
  logic [CW-1:0]     chk_idx_q, chk_idx_d;
  logic [CW-1:0]     alt_idx_q, alt_idx_d;
  logic [FW-1:0]     found_q, found_d;
  logic [CW-1:0]     pick_idx_q, pick_idx_d;
  logic [15:0]       pick_eff_q, pick_eff_d;
  logic [15:0]       cand_eff_q, cand_eff_d;
  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;
  logic [15:0]       effect_q, effect_d;
  logic [IDX_W-1:0]  index_q, index_d;
  logic [31:0]       seed_q;

  // Latched query
  logic [6:0]  q_stype_q, q_stype_d;
  logic [15:0] q_sid_q, q_sid_d;
  logic [31:0] q_act_q, q_act_d;
  logic [7:0]  q_otype_q, q_otype_d;
  logic [15:0] q_oid_q, q_oid_d;
  logic        q_first_q, q_first_d;

  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  wrtl_pkg::rule_t mem_wdata;
  wrtl_pkg::rule_t mem_rdata;

  logic                cfg_we;
  logic                draw_req;
  logic [BW-1:0]       draw_bound;
  wrtl_pkg::draw_rsp_t draw_rsp;
  logic                hit;

  // String-style compare: stop at the first shared zero character.
  function automatic logic act_eq(input logic [31:0] a, input logic [31:0] b);
    logic       eq;
    logic       stop;
    logic [7:0] ca;
    logic [7:0] cb;
    eq   = 1'b1;
    stop = 1'b0;
    for (int k = 0; k < wrtl_pkg::ACT_CMP; k++) begin
      ca = a[8*k +: 8];
      cb = b[8*k +: 8];
      if (!stop) begin
        if (ca != cb) begin
          eq   = 1'b0;
          stop = 1'b1;
        end else if (ca == 8'd0) begin
          stop = 1'b1;
        end
      end
    end
    return eq;
  endfunction

  always_comb begin
    hit = (mem_rdata.subj_type == q_stype_q) && (mem_rdata.subj_id == q_sid_q) &&
          act_eq(mem_rdata.action, q_act_q);
    if (mem_rdata.obj_type != wrtl_pkg::ANY_TYPE) begin
      hit = hit && (mem_rdata.obj_type == q_otype_q) &&
            ((mem_rdata.obj_id == wrtl_pkg::ANY_ID) || (mem_rdata.obj_id == q_oid_q));
    end
  end

  assign mem_wdata = '{subj_type: subject_type_i, subj_id: subject_id_i,
                       action: action_code_i, obj_type: object_type_i,
                       obj_id: object_id_i, effect: effect_code_i};

  assign draw_bound = BW'(found_q) + BW'(2);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    chk_valid_d = chk_valid_q;
    chk_idx_d   = chk_idx_q;
    alt_idx_d   = alt_idx_q;
    found_d     = found_q;
    pick_idx_d  = pick_idx_q;
    pick_eff_d  = pick_eff_q;
    cand_eff_d  = cand_eff_q;
    done_d      = 1'b0;
    status_d    = status_q;
    effect_d    = effect_q;
    index_d     = index_q;
    q_stype_d   = q_stype_q;
    q_sid_d     = q_sid_q;
    q_act_d     = q_act_q;
    q_otype_d   = q_otype_q;
    q_oid_d     = q_oid_q;
    q_first_d   = q_first_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = issue_q[AW-1:0];
    draw_req    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          status_d = wrtl_pkg::ST_OK;
          effect_d = '0;
          index_d  = '0;
          case (command_i)
            wrtl_pkg::CMD_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            wrtl_pkg::CMD_APPEND: begin
              if (count_q == CW'(TABLE_DEPTH)) begin
                status_d = wrtl_pkg::ST_FULL;
              end else begin
                mem_we   = 1'b1;
                effect_d = effect_code_i;
                index_d  = IDX_W'(count_q);
                count_d  = count_q + CW'(1);
              end
              done_d = 1'b1;
            end
            wrtl_pkg::CMD_QUERY: begin
              q_stype_d   = subject_type_i;
              q_sid_d     = subject_id_i;
              q_act_d     = action_code_i;
              q_otype_d   = object_type_i;
              q_oid_d     = object_id_i;
              q_first_d   = first_only_i;
              issue_d     = '0;
              chk_valid_d = 1'b0;
              state_d     = S_SEARCH;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_SEARCH: begin
        if (chk_valid_q && hit) begin
          pick_idx_d = chk_idx_q;
          pick_eff_d = mem_rdata.effect;
          if (q_first_q) begin
            done_d   = 1'b1;
            effect_d = mem_rdata.effect;
            index_d  = IDX_W'(chk_idx_q);
            state_d  = S_IDLE;
          end else begin
            alt_idx_d = chk_idx_q + CW'(1);
            found_d   = FW'(1);
            state_d   = S_ALT_READ;
          end
        end else if (issue_q < count_q) begin
          // keep one read in flight ahead of the compare
          mem_re      = 1'b1;
          mem_raddr   = issue_q[AW-1:0];
          chk_idx_d   = issue_q;
          chk_valid_d = 1'b1;
          issue_d     = issue_q + CW'(1);
        end else if (!chk_valid_q) begin
          done_d   = 1'b1;
          status_d = wrtl_pkg::ST_MISS;
          state_d  = S_IDLE;
        end else begin
          chk_valid_d = 1'b0;
        end
      end
      S_ALT_READ: begin
        if ((alt_idx_q < count_q) && (found_q < FW'(MAX_ALTERNATES))) begin
          mem_re    = 1'b1;
          mem_raddr = alt_idx_q[AW-1:0];
          state_d   = S_ALT_WAIT;
        end else begin
          done_d   = 1'b1;
          effect_d = pick_eff_q;
          index_d  = IDX_W'(pick_idx_q);
          state_d  = S_IDLE;
        end
      end
      S_ALT_WAIT: begin
        if (hit) begin
          cand_eff_d = mem_rdata.effect;
          found_d    = found_q + FW'(1);
          draw_req   = 1'b1;
          state_d    = S_ALT_DRAW;
        end else begin
          done_d   = 1'b1;
          effect_d = pick_eff_q;
          index_d  = IDX_W'(pick_idx_q);
          state_d  = S_IDLE;
        end
      end
      S_ALT_DRAW: begin
        if (draw_rsp.done) begin
          if (draw_rsp.is_zero) begin
            pick_idx_d = alt_idx_q;
            pick_eff_d = cand_eff_q;
          end
          alt_idx_d = alt_idx_q + CW'(1);
          state_d   = S_ALT_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      chk_valid_q <= 1'b0;
      done_q      <= 1'b0;
      status_q    <= '0;
      effect_q    <= '0;
      index_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      chk_valid_q <= chk_valid_d;
      done_q      <= done_d;
      status_q    <= status_d;
      effect_q    <= effect_d;
      index_q     <= index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    alt_idx_q  <= alt_idx_d;
    found_q    <= found_d;
    pick_idx_q <= pick_idx_d;
    pick_eff_q <= pick_eff_d;
    cand_eff_q <= cand_eff_d;
    q_stype_q  <= q_stype_d;
    q_sid_q    <= q_sid_d;
    q_act_q    <= q_act_d;
    q_otype_q  <= q_otype_d;
    q_oid_q    <= q_oid_d;
    q_first_q  <= q_first_d;
  end

  // APB seed register
  assign cfg_we = psel && penable && pwrite &&
                  (paddr[wrtl_pkg::PADDR_W-1:2] == wrtl_pkg::REG_SEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we) begin
      seed_q <= pwdata;
    end
  end

  assign prdata = (paddr[wrtl_pkg::PADDR_W-1:2] == wrtl_pkg::REG_SEED) ? seed_q : '0;
  assign pready = 1'b1;

  wrtl_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wrtl_draw #(
    .MAX_ALT (MAX_ALTERNATES),
    .BW      (BW)
  ) u_draw (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (cfg_we),
    .seed_i      (pwdata),
    .req_valid_i (draw_req),
    .bound_i     (draw_bound),
    .rsp_o       (draw_rsp)
  );

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign effect_out_o  = effect_q;
  assign entry_index_o = index_q;

  a_busy_ends_in_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result strobe");

  a_query_holds_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == wrtl_pkg::CMD_QUERY) |=> busy)
    else $error("query request did not start a scan");

  a_draw_rsp_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_rsp.done |-> state_q == S_ALT_DRAW)
    else $error("draw response outside of an alternate draw");

  a_miss_is_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == wrtl_pkg::ST_MISS) |-> (effect_out_o == '0 && entry_index_o == '0))
    else $error("miss result carries an entry");

endmodule
